// ===== design/lifo_stack_with_search_defines.svh =====
// Assertion macros used by the stack top level.
`ifndef LIFO_STACK_WITH_SEARCH_DEFINES_SVH
`define LIFO_STACK_WITH_SEARCH_DEFINES_SVH
`ifndef SYNTHESIS
// Assert that prop holds at every clock edge outside reset.
`define LSWS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Assert that expr is never true outside reset.
`define LSWS_ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define LSWS_ASSERT(lbl, clk, rst, prop, msg)
`define LSWS_ASSERT_NEVER(lbl, clk, rst, expr, msg)
`endif
`endif

// ===== design/lsws_pkg.sv =====
// Shared types and constants for the searchable stack.
package lsws_pkg;

   localparam int MAX_RESULTS = 16;
   localparam int FOUND_W     = $clog2(MAX_RESULTS + 1);

   typedef enum logic [1:0] {
      OP_PUSH   = 2'd0,
      OP_POP    = 2'd1,
      OP_SEARCH = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_EMPTY    = 3'd1,
      ST_FULL     = 3'd2,
      ST_FOUND    = 3'd3,
      ST_NOTFOUND = 3'd4
   } status_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       accept_init;
      logic       push_write;
      logic       pop_read;
      logic       scan_issue;
      logic       scan_adv;
      logic       cmp_take;
      logic       emit;
      logic       emit_pop;
      status_type emit_status;
      logic       emit_last;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic slot_free;
      logic empty;
      logic full;
      logic scan_more;
      logic cmp_valid;
      logic match;
      logic pend_valid;
      logic limit_hit;
   } stat_type;

endpackage

// ===== design/lsws_dp.sv =====
// Datapath: stack memory, entry count, search pipeline and response register.
module lsws_dp import lsws_pkg::*; #(
   parameter int DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic signed [31:0] req_value,
   input  cmd_type            cmd,
   output stat_type           st,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output logic [2:0]         rsp_status,
   output logic signed [31:0] rsp_data,
   output logic [4:0]         rsp_position,
   output logic               rsp_last
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int AW = $clog2(DEPTH);

   logic signed [31:0] mem [DEPTH];
   logic signed [31:0] key_ff;
   logic signed [31:0] rd_data_ff;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      scan_idx_ff, scan_idx_in;
   logic [CW-1:0]      top_idx;
   logic [4:0]         rd_pos_ff;
   logic [4:0]         pend_pos_ff;
   logic               cmp_valid_ff, cmp_valid_in;
   logic               pend_valid_ff, pend_valid_in;
   logic [FOUND_W-1:0] found_ff, found_in;
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff;
   logic signed [31:0] rsp_data_ff;
   logic [4:0]         rsp_position_ff;
   logic               rsp_last_ff;
   logic [AW-1:0]      rd_addr;
   logic [AW-1:0]      wr_addr;

   assign top_idx = count_ff - CW'(1);
   assign rd_addr = AW'(top_idx - (cmd.scan_issue ? scan_idx_ff : CW'(0)));
   assign wr_addr = AW'(count_ff);

   always_ff @(posedge clock) begin
      if (cmd.push_write) begin
         mem[wr_addr] <= key_ff;
      end
      if (cmd.pop_read || cmd.scan_issue) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      count_in      = count_ff;
      scan_idx_in   = scan_idx_ff;
      cmp_valid_in  = cmp_valid_ff;
      pend_valid_in = pend_valid_ff;
      found_in      = found_ff;
      if (cmd.push_write) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.pop_read) begin
         count_in = count_ff - CW'(1);
      end
      if (cmd.accept_init) begin
         scan_idx_in   = '0;
         cmp_valid_in  = 1'b0;
         pend_valid_in = 1'b0;
         found_in      = '0;
      end else begin
         if (cmd.scan_issue) begin
            scan_idx_in = scan_idx_ff + CW'(1);
         end
         if (cmd.scan_adv) begin
            cmp_valid_in = cmd.scan_issue;
         end
         if (cmd.cmp_take) begin
            pend_valid_in = 1'b1;
            found_in      = found_ff + FOUND_W'(1);
         end
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         scan_idx_ff   <= '0;
         cmp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         found_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         scan_idx_ff   <= scan_idx_in;
         cmp_valid_ff  <= cmp_valid_in;
         pend_valid_ff <= pend_valid_in;
         found_ff      <= found_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept_init) begin
         key_ff <= req_value;
      end
      if (cmd.scan_issue) begin
         rd_pos_ff <= 5'(scan_idx_ff + CW'(1));
      end
      if (cmd.cmp_take) begin
         pend_pos_ff <= rd_pos_ff;
      end
      if (cmd.emit) begin
         rsp_status_ff   <= cmd.emit_status;
         rsp_data_ff     <= cmd.emit_pop ? rd_data_ff : 32'sd0;
         rsp_position_ff <= (cmd.emit_status == ST_FOUND) ? pend_pos_ff : 5'd0;
         rsp_last_ff     <= cmd.emit_last;
      end
   end

   always_comb begin
      st.slot_free  = !rsp_valid_ff || rsp_ready;
      st.empty      = (count_ff == CW'(0));
      st.full       = (count_ff == CW'(DEPTH));
      st.scan_more  = (scan_idx_ff < count_ff);
      st.cmp_valid  = cmp_valid_ff;
      st.match      = (rd_data_ff == key_ff);
      st.pend_valid = pend_valid_ff;
      st.limit_hit  = (found_ff == FOUND_W'(MAX_RESULTS - 1));
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_data     = rsp_data_ff;
   assign rsp_position = rsp_position_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

// ===== design/lsws_ctrl.sv =====
// Controller: request handshake and the sequencing of push, pop and search.
module lsws_ctrl import lsws_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [1:0] req_opcode,
   output logic       req_ready,
   input  stat_type   st,
   output cmd_type    cmd
);

   typedef enum logic [4:0] {
      S_IDLE    = 5'b00001,
      S_EXEC    = 5'b00010,
      S_POP_OUT = 5'b00100,
      S_SCAN    = 5'b01000,
      S_FINISH  = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   op_type    op_ff;
   logic      stall;
   logic      take;
   logic      end_now;
   logic      issue;

   assign req_ready = (state_ff == S_IDLE);

   // A new match cannot retire the pending one while the response slot is busy.
   assign stall   = st.cmp_valid && st.match && st.pend_valid && !st.slot_free;
   assign take    = st.cmp_valid && st.match;
   assign end_now = take && st.limit_hit;
   assign issue   = st.scan_more && !end_now;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept_init = 1'b1;
               state_in = (op_type'(req_opcode) == OP_NONE) ? S_IDLE : S_EXEC;
            end
         end
         S_EXEC: begin
            case (op_ff)
               OP_PUSH: begin
                  if (st.slot_free) begin
                     cmd.emit        = 1'b1;
                     cmd.emit_last   = 1'b1;
                     cmd.push_write  = !st.full;
                     cmd.emit_status = st.full ? ST_FULL : ST_OK;
                     state_in        = S_IDLE;
                  end
               end
               OP_POP: begin
                  if (!st.empty) begin
                     cmd.pop_read = 1'b1;
                     state_in     = S_POP_OUT;
                  end else if (st.slot_free) begin
                     cmd.emit        = 1'b1;
                     cmd.emit_last   = 1'b1;
                     cmd.emit_status = ST_EMPTY;
                     state_in        = S_IDLE;
                  end
               end
               OP_SEARCH: begin
                  if (!st.empty) begin
                     state_in = S_SCAN;
                  end else if (st.slot_free) begin
                     cmd.emit        = 1'b1;
                     cmd.emit_last   = 1'b1;
                     cmd.emit_status = ST_EMPTY;
                     state_in        = S_IDLE;
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_POP_OUT: begin
            if (st.slot_free) begin
               cmd.emit        = 1'b1;
               cmd.emit_pop    = 1'b1;
               cmd.emit_last   = 1'b1;
               cmd.emit_status = ST_OK;
               state_in        = S_IDLE;
            end
         end
         S_SCAN: begin
            if (!stall) begin
               cmd.scan_adv   = 1'b1;
               cmd.scan_issue = issue;
               cmd.cmp_take   = take;
               if (take && st.pend_valid) begin
                  cmd.emit        = 1'b1;
                  cmd.emit_status = ST_FOUND;
               end
               if (!issue) begin
                  state_in = S_FINISH;
               end
            end
         end
         S_FINISH: begin
            if (st.slot_free) begin
               cmd.emit        = 1'b1;
               cmd.emit_last   = 1'b1;
               cmd.emit_status = st.pend_valid ? ST_FOUND : ST_NOTFOUND;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept_init) begin
         op_ff <= op_type'(req_opcode);
      end
   end

endmodule

// ===== design/lifo_stack_with_search.sv =====
// Top level of the bounded LIFO stack with search.
// A bounded stack of DEPTH signed 32-bit words behind a valid/ready request
// channel and a valid/ready response channel. A request carries an opcode
// and a value: push stores the value (status full when DEPTH words are
// held), pop returns the top word (status empty on an empty stack), and
// search walks from the top and returns one found response per matching
// word, up to MAX_RESULTS, with its 1-based position from the top, or a
// single not-found or empty response; the final response of every request
// has last set. Requests are handled one at a time and the response
// register decouples the two sides, so a request is taken while its
// predecessor's final response still waits. The stack memory has a single
// read port, which the search reads one word per cycle while no match
// waits on a busy response slot. A busy response side holds the block
// until the response slot is free. Opcode 3 is dropped with no response.
`include "lifo_stack_with_search_defines.svh"
module lifo_stack_with_search import lsws_pkg::*; #(
   parameter int DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_opcode,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_status,
   output logic signed [31:0] rsp_data,
   output logic [4:0]         rsp_position,
   output logic               rsp_last
);

   cmd_type  dp_cmd;
   stat_type dp_stat;

   // Sequence each request and drive the datapath commands.
   lsws_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .req_ready  (req_ready),
      .st         (dp_stat),
      .cmd        (dp_cmd)
   );

   // Hold the stack, the search pipeline and the response register.
   lsws_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .req_value    (req_value),
      .cmd          (dp_cmd),
      .st           (dp_stat),
      .rsp_ready    (rsp_ready),
      .rsp_valid    (rsp_valid),
      .rsp_status   (rsp_status),
      .rsp_data     (rsp_data),
      .rsp_position (rsp_position),
      .rsp_last     (rsp_last)
   );

   // Never overwrite a response that has not been taken.
   `LSWS_ASSERT_NEVER(a_no_rsp_overwrite, clock, reset, dp_cmd.emit && rsp_valid && !rsp_ready, "response overwritten")
   // Never write past the top of a full stack.
   `LSWS_ASSERT_NEVER(a_no_push_full, clock, reset, dp_cmd.push_write && dp_stat.full, "push on full stack")
   // Never pop from an empty stack.
   `LSWS_ASSERT_NEVER(a_no_pop_empty, clock, reset, dp_cmd.pop_read && dp_stat.empty, "pop on empty stack")
   // Drop ready in the cycle after taking a request other than opcode 3.
   `LSWS_ASSERT(a_busy_after_accept, clock, reset, (req_valid && req_ready && req_opcode != OP_NONE) |=> !req_ready, "ready after accept")

endmodule
